### rtl/scrv_pkg.sv
// ----------------------------------------------------------------------------
// scrv_pkg: shared types and constants of the victim selector
// Field widths, score arithmetic widths and the queue entry layout.
// ----------------------------------------------------------------------------
package scrv_pkg;

    localparam int SLOT_W  = 16;                 // slot field
    localparam int COST_W  = 16;                 // cost field
    localparam int HITS_W  = 16;                 // hit count field
    localparam int TIME_W  = 32;                 // time fields
    localparam int PEN_W   = 17;                 // Q1.16 penalty register
    localparam int PRE_W   = 32;                 // cost * (hits + 1)
    localparam int NUM_W   = 50;                 // score numerator
    localparam int AGE_W   = 33;                 // score denominator
    localparam int LO_W    = 32;                 // low split of numerator / age
    localparam int HI_W    = NUM_W - LO_W;       // high split of numerator
    localparam int PROD_W  = NUM_W + AGE_W;      // cross product
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic [PEN_W-1:0] Q16_ONE       = 17'd65536;
    localparam logic [PEN_W-1:0] PENALTY_RESET = 17'd6554;

    // One classified candidate, front to back
    typedef struct packed {
        logic              valid;   // sample found an entry
        logic              last;    // final sample of the decision
        logic [SLOT_W-1:0] slot;
        logic [NUM_W-1:0]  num;
        logic [AGE_W-1:0]  age;
    } t_cand;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### rtl/scrv_front.sv
// ----------------------------------------------------------------------------
// scrv_front: candidate classifier
// Two stage pipeline: clamp the age and form cost*(hits+1), then apply the
// penalty scale and push the numerator/age pair into the queue.
// ----------------------------------------------------------------------------
module scrv_front #(
    parameter int SLOT_KEEP = 16,
    parameter int TIME_KEEP = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cand_valid,
    input  logic [scrv_pkg::SLOT_W-1:0]   i_cand_slot,
    input  logic [scrv_pkg::COST_W-1:0]   i_cand_cost,
    input  logic [scrv_pkg::HITS_W-1:0]   i_cand_hits,
    input  logic [scrv_pkg::TIME_W-1:0]   i_cand_last_access,
    input  logic [scrv_pkg::TIME_W-1:0]   i_now_count,
    input  logic                          i_last_sample,
    input  logic [scrv_pkg::PEN_W-1:0]    i_penalty,
    input  scrv_pkg::t_q_status           i_q_status,
    output logic                          o_push,
    output scrv_pkg::t_cand               o_entry
);
    import scrv_pkg::*;

    logic                 r_s1_valid, n_s1_valid;
    logic                 r_s1_cand;
    logic                 r_s1_last;
    logic [SLOT_W-1:0]    r_s1_slot;
    logic [PRE_W-1:0]     r_s1_pre;
    logic [PEN_W-1:0]     r_s1_scale;
    logic [AGE_W-1:0]     r_s1_age;

    logic                 r_s2_valid, n_s2_valid;
    t_cand                r_s2;

    logic                 s2_ok;
    logic                 in_acc;
    logic [TIME_KEEP-1:0] last_t;
    logic [TIME_KEEP-1:0] now_t;
    logic [TIME_KEEP:0]   diff;
    logic [AGE_W-1:0]     age;
    logic [HITS_W:0]      hits_p1;
    logic [PRE_W-1:0]     pre;
    logic [NUM_W-1:0]     num;

    always_comb begin
        s2_ok      = !r_s2_valid || !i_q_status.full;
        o_in_ready = !r_s1_valid || s2_ok;
        in_acc     = i_in_valid && o_in_ready;
        o_push     = r_s2_valid && !i_q_status.full;
        o_entry    = r_s2;

        // age = now - last + 1, clamped to one when last is ahead of now
        last_t = i_cand_last_access[TIME_KEEP-1:0];
        now_t  = i_now_count[TIME_KEEP-1:0];
        diff   = {1'b0, now_t} - {1'b0, last_t} + (TIME_KEEP+1)'(1);
        age    = (last_t > now_t) ? AGE_W'(1) : AGE_W'(diff);

        hits_p1 = {1'b0, i_cand_hits} + (HITS_W+1)'(1);
        pre     = PRE_W'(i_cand_cost) * PRE_W'(hits_p1);
        num     = NUM_W'(r_s1_pre) * NUM_W'(r_s1_scale);

        n_s1_valid = in_acc ? 1'b1 : (s2_ok ? 1'b0 : r_s1_valid);
        n_s2_valid = s2_ok ? r_s1_valid : r_s2_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cand  <= i_cand_valid;
            r_s1_last  <= i_last_sample;
            r_s1_slot  <= SLOT_W'(i_cand_slot[SLOT_KEEP-1:0]);
            r_s1_pre   <= pre;
            r_s1_scale <= (i_cand_hits == '0) ? i_penalty : Q16_ONE;
            r_s1_age   <= age;
        end
        if (s2_ok && r_s1_valid) begin
            r_s2.valid <= r_s1_cand;
            r_s2.last  <= r_s1_last;
            r_s2.slot  <= r_s1_slot;
            r_s2.num   <= num;
            r_s2.age   <= r_s1_age;
        end
    end

endmodule

### rtl/scrv_queue.sv
// ----------------------------------------------------------------------------
// scrv_queue: two entry queue between classifier and selector
// Register based FIFO; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module scrv_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  scrv_pkg::t_cand      i_entry,
    input  logic                 i_pop,
    output scrv_pkg::t_cand      o_head,
    output scrv_pkg::t_q_status  o_status
);
    import scrv_pkg::*;

    t_cand             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    always_comb begin
        o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
        o_status.empty = (r_count == '0);
        o_head         = r_mem[r_rd];
        do_push = i_push && !o_status.full;
        do_pop  = i_pop && !o_status.empty;
        n_wr    = do_push ? r_wr + QPTR_W'(1) : r_wr;
        n_rd    = do_pop  ? r_rd + QPTR_W'(1) : r_rd;
        n_count = r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // the classifier only pushes into free space
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full queue");

endmodule

### rtl/scrv_back.sv
// ----------------------------------------------------------------------------
// scrv_back: minimum score selector
// Pops candidates, compares by exact cross multiplication over several
// steps, holds the best one and emits the victim on the final sample.
// ----------------------------------------------------------------------------
module scrv_back #(
    parameter int SLOT_KEEP = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  scrv_pkg::t_cand              i_head,
    input  scrv_pkg::t_q_status          i_q_status,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [scrv_pkg::SLOT_W-1:0]  o_victim_slot,
    output logic                         o_victim_found
);
    import scrv_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_M0   = 3'd1;
    localparam logic [2:0] ST_M1   = 3'd2;
    localparam logic [2:0] ST_A1   = 3'd3;
    localparam logic [2:0] ST_A2   = 3'd4;
    localparam logic [2:0] ST_CMP  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]           r_state, n_state;
    t_cand                r_cur;
    logic                 r_have_best, n_have_best;
    logic [SLOT_KEEP-1:0] r_best_slot;
    logic [NUM_W-1:0]     r_best_num;
    logic [AGE_W-1:0]     r_best_age;
    logic [PROD_W-1:0]    r_l_acc, r_r_acc;
    logic [NUM_W-1:0]     r_l_pp, r_r_pp;
    logic                 r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_found;

    logic                 take_head;   // first valid sample, no compare
    logic                 take_cur;    // compared and lower
    logic                 emit;
    logic                 out_free;
    logic [LO_W-1:0]      mul_l_a, mul_r_a;
    logic [2*LO_W-1:0]    mul_l, mul_r;

    always_comb begin
        out_free = !r_out_valid || i_out_ready;
        o_pop    = (r_state == ST_IDLE) && !i_q_status.empty;

        // one multiplier per side, low then high numerator half
        mul_l_a = (r_state == ST_M0) ? r_cur.num[LO_W-1:0]
                                     : LO_W'(r_cur.num[NUM_W-1:LO_W]);
        mul_r_a = (r_state == ST_M0) ? r_best_num[LO_W-1:0]
                                     : LO_W'(r_best_num[NUM_W-1:LO_W]);
        mul_l   = mul_l_a * r_best_age[LO_W-1:0];
        mul_r   = mul_r_a * r_cur.age[LO_W-1:0];

        take_head = o_pop && i_head.valid && !r_have_best;
        take_cur  = (r_state == ST_CMP) && (r_l_acc < r_r_acc);
        emit      = (r_state == ST_FIN) && r_cur.last && out_free;

        n_state     = r_state;
        n_have_best = r_have_best;
        n_out_valid = i_out_ready ? 1'b0 : r_out_valid;

        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    if (i_head.valid && r_have_best) begin
                        n_state = ST_M0;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
                if (take_head) begin
                    n_have_best = 1'b1;
                end
            end
            ST_M0:  n_state = ST_M1;
            ST_M1:  n_state = ST_A1;
            ST_A1:  n_state = ST_A2;
            ST_A2:  n_state = ST_CMP;
            ST_CMP: n_state = ST_FIN;
            ST_FIN: begin
                if (!r_cur.last) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_state     = ST_IDLE;
                    n_have_best = 1'b0;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have_best <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have_best <= n_have_best;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (take_head) begin
            r_best_slot <= i_head.slot[SLOT_KEEP-1:0];
            r_best_num  <= i_head.num;
            r_best_age  <= i_head.age;
        end
        if (take_cur) begin
            r_best_slot <= r_cur.slot[SLOT_KEEP-1:0];
            r_best_num  <= r_cur.num;
            r_best_age  <= r_cur.age;
        end
        case (r_state)
            ST_M0: begin
                r_l_acc <= PROD_W'(mul_l);
                r_r_acc <= PROD_W'(mul_r);
            end
            ST_M1: begin
                r_l_pp <= mul_l[NUM_W-1:0];
                r_r_pp <= mul_r[NUM_W-1:0];
            end
            ST_A1: begin
                r_l_acc <= r_l_acc + (PROD_W'(r_l_pp) << LO_W);
                r_r_acc <= r_r_acc + (PROD_W'(r_r_pp) << LO_W);
            end
            ST_A2: begin
                // top age bit carries the whole other numerator
                if (r_best_age[AGE_W-1]) begin
                    r_l_acc <= r_l_acc + (PROD_W'(r_cur.num) << LO_W);
                end
                if (r_cur.age[AGE_W-1]) begin
                    r_r_acc <= r_r_acc + (PROD_W'(r_best_num) << LO_W);
                end
            end
            default: ;
        endcase
        if (emit) begin
            r_out_slot  <= r_have_best ? SLOT_W'(r_best_slot) : '0;
            r_out_found <= r_have_best;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_victim_slot  = r_out_slot;
    assign o_victim_found = r_out_found;

    a_cmp_needs_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_M0) |-> r_have_best)
        else $error("compare started with no held candidate");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> !r_have_best && r_out_valid)
        else $error("decision end did not clear and report");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_slot == '0))
        else $error("not-found result with nonzero slot");

endmodule

### rtl/sampled_cost_recency_victim_select_top.sv
// ----------------------------------------------------------------------------
// sampled_cost_recency_victim_select_top: sampled cost/recency victim select
// Picks the lowest cost*(hits+1)/age candidate of a sampling run.
// ----------------------------------------------------------------------------
// Feed the sampled candidates of one eviction decision in order, one input
// transaction each, and mark the final one with i_last_sample. Each valid
// candidate gets the score cost*(hits+1)/age with age = now-last+1 (one when
// the last access lies ahead of now); a never-hit candidate is scaled by the
// Q1.16 one-hit penalty written on the configuration channel (reset 0.1).
// Scores are compared exactly by cross multiplication; ties keep the earlier
// candidate and empty samples are skipped. The final sample yields one
// output transaction with the victim slot, or found = 0 and slot 0 when no
// valid sample was seen, and the block then starts a fresh decision.
// The selector takes a new sample only when idle: an empty sample or the
// first valid one of a decision is popped and retired; every later valid one
// is popped, runs two steps of the shared 32x32 multiplier per side and two
// accumulate steps over the 83-bit cross products, then is compared and
// retired. A 2-entry queue decouples the classifier, so up to four candidates
// are taken ahead of the selector. Configuration is always ready; write it
// only while no decision is in flight.
// ----------------------------------------------------------------------------
module sampled_cost_recency_victim_select_top #(
    parameter int SLOT_BITS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // candidate channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cand_valid,
    input  logic [scrv_pkg::SLOT_W-1:0]   i_cand_slot,
    input  logic [scrv_pkg::COST_W-1:0]   i_cand_cost,
    input  logic [scrv_pkg::HITS_W-1:0]   i_cand_hits,
    input  logic [scrv_pkg::TIME_W-1:0]   i_cand_last_access,
    input  logic [scrv_pkg::TIME_W-1:0]   i_now_count,
    input  logic                          i_last_sample,
    // victim channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [scrv_pkg::SLOT_W-1:0]   o_victim_slot,
    output logic                          o_victim_found,
    // configuration channel: one-hit penalty
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [scrv_pkg::PEN_W-1:0]    i_cfg_data
);
    import scrv_pkg::*;

    // slot and time bits kept from the fixed-width fields
    localparam int SLOT_KEEP = (SLOT_BITS < SLOT_W) ? SLOT_BITS : SLOT_W;
    localparam int TIME_KEEP = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;

    logic [PEN_W-1:0] r_one_hit_penalty;
    logic             push;
    logic             pop;
    t_cand            entry;
    t_cand            head;
    t_q_status        q_status;

    // Accept every configuration transaction; hold the penalty until rewritten.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_hit_penalty <= PENALTY_RESET;
        end else if (i_cfg_valid) begin
            r_one_hit_penalty <= i_cfg_data;
        end
    end

    // Classify: clamp age, build the exact numerator, push into the queue.
    scrv_front #(
        .SLOT_KEEP (SLOT_KEEP),
        .TIME_KEEP (TIME_KEEP)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cand_valid       (i_cand_valid),
        .i_cand_slot        (i_cand_slot),
        .i_cand_cost        (i_cand_cost),
        .i_cand_hits        (i_cand_hits),
        .i_cand_last_access (i_cand_last_access),
        .i_now_count        (i_now_count),
        .i_last_sample      (i_last_sample),
        .i_penalty          (r_one_hit_penalty),
        .i_q_status         (q_status),
        .o_push             (push),
        .o_entry            (entry)
    );

    // Decouple classifier and selector so each stalls on its own.
    scrv_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // Select: keep the minimum, report on the final sample.
    scrv_back #(
        .SLOT_KEEP (SLOT_KEEP)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_victim_slot  (o_victim_slot),
        .o_victim_found (o_victim_found)
    );

endmodule

### test/tb_sampled_cost_recency_victim_select_top.sv
// ----------------------------------------------------------------------------
// tb_sampled_cost_recency_victim_select_top: victim selector testbench
// Feeds sampled-candidate decisions through the candidate channel, predicts
// the victim of each decision with an exact cost*(hits+1)/age score model
// and compares every victim transaction field by field.
// ----------------------------------------------------------------------------
module tb_sampled_cost_recency_victim_select_top;

    timeunit 1ns;
    timeprecision 1ps;

    import scrv_pkg::*;

    // Cycles to let the block settle once the last victim has come back
    localparam int DRAIN_CYCLES = 40;
    // Item counts at which the random phases stop
    localparam int RANDOM_END   = 1150;
    localparam int STEADY_END   = 1450;
    // Transactions between penalty changes in the random phase
    localparam int CFG_SPACING  = 250;

    // One sampled candidate as driven on the candidate channel
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [COST_W-1:0] cost;
        logic [HITS_W-1:0] hits;
        logic [TIME_W-1:0] last_acc;
        logic [TIME_W-1:0] now_count;
        logic              is_last;
    } t_cand_stim;

    // One predicted victim transaction
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              found;
    } t_victim;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_cand_valid;
    logic [SLOT_W-1:0]   i_cand_slot;
    logic [COST_W-1:0]   i_cand_cost;
    logic [HITS_W-1:0]   i_cand_hits;
    logic [TIME_W-1:0]   i_cand_last_access;
    logic [TIME_W-1:0]   i_now_count;
    logic                i_last_sample;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [SLOT_W-1:0]   o_victim_slot;
    logic                o_victim_found;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [PEN_W-1:0]    i_cfg_data;

    // Scoring model: penalty register and the held best candidate
    logic [PEN_W-1:0]    penalty_reg;
    logic                held_valid;
    logic [SLOT_W-1:0]   held_slot;
    logic [NUM_W-1:0]    held_num;
    logic [AGE_W-1:0]    held_age;

    t_victim             victim_q[$];
    int                  mismatch_cnt;
    int                  items_sent;
    logic                steady;      // high: neither side idles

    // Last valid candidate drawn, reused to force equal scores
    t_cand_stim          tie_src;
    logic                tie_ok;

    sampled_cost_recency_victim_select_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cand_valid       (i_cand_valid),
        .i_cand_slot        (i_cand_slot),
        .i_cand_cost        (i_cand_cost),
        .i_cand_hits        (i_cand_hits),
        .i_cand_last_access (i_cand_last_access),
        .i_now_count        (i_now_count),
        .i_last_sample      (i_last_sample),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_victim_slot      (o_victim_slot),
        .o_victim_found     (o_victim_found),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Scoring model
    // ------------------------------------------------------------------------

    // Score one accepted candidate against the held best; on the final sample
    // queue the victim and clear the decision.
    task automatic update_victim_choice(input t_cand_stim c);
        logic [NUM_W-1:0]  cost_w;
        logic [NUM_W-1:0]  hits_w;
        logic [NUM_W-1:0]  scale_w;
        logic [NUM_W-1:0]  num;
        logic [AGE_W-1:0]  age;
        logic [PROD_W-1:0] num_p;
        logic [PROD_W-1:0] age_p;
        logic [PROD_W-1:0] held_num_p;
        logic [PROD_W-1:0] held_age_p;
        t_victim           v;
        if (c.valid) begin
            // Clamp the age to one when the last access lies ahead of now
            if (c.last_acc > c.now_count) begin
                age = AGE_W'(1);
            end else begin
                age = AGE_W'(c.now_count);
                age = age - AGE_W'(c.last_acc) + AGE_W'(1);
            end
            cost_w  = NUM_W'(c.cost);
            hits_w  = NUM_W'(c.hits);
            hits_w  = hits_w + NUM_W'(1);
            scale_w = NUM_W'((c.hits == '0) ? penalty_reg : Q16_ONE);
            num     = cost_w * hits_w * scale_w;
            // Cross multiply: num/age < held_num/held_age, exact
            num_p      = PROD_W'(num);
            age_p      = PROD_W'(age);
            held_num_p = PROD_W'(held_num);
            held_age_p = PROD_W'(held_age);
            if (!held_valid || (num_p * held_age_p < held_num_p * age_p)) begin
                held_valid = 1'b1;
                held_slot  = c.slot;
                held_num   = num;
                held_age   = age;
            end
        end
        if (c.is_last) begin
            v.found = held_valid;
            v.slot  = held_valid ? held_slot : '0;
            victim_q.push_back(v);
            held_valid = 1'b0;
            held_slot  = '0;
            held_num   = '0;
            held_age   = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: check victims, track the penalty, score accepted candidates
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_victim exp_v;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (victim_q.size() == 0) begin
                    $error("victim transaction with no decision pending: slot %0d found %0b",
                           o_victim_slot, o_victim_found);
                    mismatch_cnt++;
                end else begin
                    exp_v = victim_q.pop_front();
                    if (o_victim_slot !== exp_v.slot) begin
                        $error("victim_slot: expected %0d, got %0d",
                               exp_v.slot, o_victim_slot);
                        mismatch_cnt++;
                    end
                    if (o_victim_found !== exp_v.found) begin
                        $error("victim_found: expected %0b, got %0b",
                               exp_v.found, o_victim_found);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                penalty_reg = i_cfg_data;
            if (i_in_valid && o_in_ready)
                update_victim_choice({i_cand_valid, i_cand_slot, i_cand_cost, i_cand_hits,
                                      i_cand_last_access, i_now_count, i_last_sample});
        end
    end

    // Stall the victim channel with a chance of about one in five, except in steady runs
    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 20);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Send one candidate transaction; enter and leave at a falling edge.
    // Keep valid high across back-to-back transactions, drop it only in gaps.
    task automatic send_cand(input t_cand_stim c);
        if (!steady) begin
            while ($urandom_range(99) < 20) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid         <= 1'b1;
        i_cand_valid       <= c.valid;
        i_cand_slot        <= c.slot;
        i_cand_cost        <= c.cost;
        i_cand_hits        <= c.hits;
        i_cand_last_access <= c.last_acc;
        i_now_count        <= c.now_count;
        i_last_sample      <= c.is_last;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic valid, input logic [SLOT_W-1:0] slot,
                               input logic [COST_W-1:0] cost,
                               input logic [HITS_W-1:0] hits,
                               input logic [TIME_W-1:0] last_acc,
                               input logic [TIME_W-1:0] now_count, input logic is_last);
        t_cand_stim c;
        c.valid     = valid;
        c.slot      = slot;
        c.cost      = cost;
        c.hits      = hits;
        c.last_acc  = last_acc;
        c.now_count = now_count;
        c.is_last   = is_last;
        send_cand(c);
    endtask

    // Hold off the sender until every victim has come back, then let the
    // block settle; leave at a fresh falling edge.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (victim_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write the one-hit penalty while no decision is in flight
    task automatic write_penalty(input logic [PEN_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random candidates
    // ------------------------------------------------------------------------
    function automatic t_cand_stim rand_cand();
        t_cand_stim c;
        int         pick;
        c.valid   = ($urandom_range(99) >= 15);
        c.slot    = SLOT_W'($urandom);
        c.is_last = 1'b0;
        if (tie_ok && $urandom_range(99) < 10) begin
            // Reuse an earlier score under a new slot to hit ties
            c.cost      = tie_src.cost;
            c.hits      = tie_src.hits;
            c.last_acc  = tie_src.last_acc;
            c.now_count = tie_src.now_count;
        end else begin
            pick = $urandom_range(99);
            if (pick < 5)       c.cost = '0;
            else if (pick < 45) c.cost = COST_W'($urandom_range(255));
            else                c.cost = COST_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 30)      c.hits = '0;
            else if (pick < 60) c.hits = HITS_W'($urandom_range(7, 1));
            else if (pick < 85) c.hits = HITS_W'($urandom);
            else                c.hits = '1;
            c.now_count = $urandom;
            pick = $urandom_range(99);
            if (pick < 50)      c.last_acc = c.now_count - $urandom_range(15);
            else if (pick < 75) c.last_acc = c.now_count - $urandom_range(65535);
            else if (pick < 90) c.last_acc = $urandom;
            else                c.last_acc = c.now_count + $urandom_range(1000, 1);
        end
        if (c.valid) begin
            tie_src = c;
            tie_ok  = 1'b1;
        end
        return c;
    endfunction

    // Mostly short decisions, a few long sampling runs
    task automatic run_decision();
        int         len;
        int         pick;
        t_cand_stim c;
        pick = $urandom_range(99);
        if (pick < 60)      len = $urandom_range(4, 1);
        else if (pick < 90) len = $urandom_range(12, 5);
        else                len = $urandom_range(32, 13);
        for (int i = 0; i < len; i++) begin
            c         = rand_cand();
            c.is_last = (i == len - 1);
            send_cand(c);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Directed decisions under the reset penalty of 0.1
    task automatic test_reset_penalty();
        // Single never-hit candidate, largest cost, largest age, top slot
        send_fields(1'b1, 16'hFFFF, 16'hFFFF, 0, 32'h0, 32'hFFFF_FFFF, 1'b1);
        // Only an empty sample: no victim, ask for a resample
        send_fields(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // Empty first, then a tie that keeps the earlier slot, a clamped age
        // with the largest cost and hits, and an empty sample ending it
        send_fields(1'b0, 1, 1, 1, 32'd1, 32'd1, 1'b0);
        send_fields(1'b1, 5, 10, 3, 32'd100, 32'd100, 1'b0);
        send_fields(1'b1, 6, 10, 3, 32'd100, 32'd100, 1'b0);
        send_fields(1'b1, 7, 16'hFFFF, 16'hFFFF, 32'd200, 32'd100, 1'b0);
        send_fields(1'b0, 8, 0, 0, 32'd0, 32'd0, 1'b1);
        // Zero cost wins; a second zero score keeps the earlier one
        send_fields(1'b1, 9, 100, 1, 32'd91, 32'd100, 1'b0);
        send_fields(1'b1, 10, 0, 1, 32'd91, 32'd100, 1'b0);
        send_fields(1'b1, 11, 0, 0, 32'd0, 32'd0, 1'b1);
        // Penalty pulls a never-hit candidate under a hit one
        send_fields(1'b1, 1, 10, 1, 32'd50, 32'd50, 1'b0);
        send_fields(1'b1, 2, 10, 0, 32'd50, 32'd50, 1'b1);
        // Valid candidate kept across an empty final sample, slot zero too
        send_fields(1'b1, 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_fields(1'b1, 16'h1234, 16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_fields(1'b0, 3, 3, 3, 32'd3, 32'd3, 1'b1);
    endtask

    // Penalty at zero, exactly one and the register maximum
    task automatic test_penalty_extremes();
        write_penalty('0);
        send_fields(1'b1, 3, 16'hFFFF, 5, 32'd7, 32'd7, 1'b0);
        send_fields(1'b1, 4, 16'hFFFF, 0, 32'd7, 32'd7, 1'b1);
        write_penalty(Q16_ONE);
        send_fields(1'b1, 20, 4, 1, 32'd9, 32'd10, 1'b0);
        send_fields(1'b1, 21, 8, 0, 32'd9, 32'd10, 1'b1);
        write_penalty('1);
        send_fields(1'b1, 30, 1, 0, 32'd0, 32'd0, 1'b0);
        send_fields(1'b1, 31, 1, 1, 32'd0, 32'd0, 1'b0);
        send_fields(1'b1, 32, 16'hFFFF, 0, 32'd0, 32'hFFFF_FFFF, 1'b1);
    endtask

    // Random decisions with the penalty changed now and then
    task automatic test_random_decisions();
        int          since_cfg;
        int          before_cnt;
        logic [PEN_W-1:0] pen;
        since_cfg = 0;
        while (items_sent < RANDOM_END) begin
            if (since_cfg >= CFG_SPACING) begin
                case ($urandom_range(5))
                    0:       pen = PENALTY_RESET;
                    1:       pen = '0;
                    2:       pen = Q16_ONE;
                    3:       pen = '1;
                    4:       pen = PEN_W'($urandom_range(131071));
                    default: pen = PEN_W'($urandom_range(65536));
                endcase
                write_penalty(pen);
                since_cfg = 0;
            end
            before_cnt = items_sent;
            run_decision();
            since_cfg += items_sent - before_cnt;
        end
    endtask

    // Back-to-back run: no gaps on the candidates, no stalls on the victims
    task automatic test_back_to_back();
        write_penalty(PENALTY_RESET);
        steady = 1'b1;
        while (items_sent < STEADY_END)
            run_decision();
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_cand_valid       = 1'b0;
        i_cand_slot        = '0;
        i_cand_cost        = '0;
        i_cand_hits        = '0;
        i_cand_last_access = '0;
        i_now_count        = '0;
        i_last_sample      = 1'b0;
        i_out_ready        = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_data         = '0;
        steady             = 1'b0;
        tie_ok             = 1'b0;
        tie_src            = '0;
        mismatch_cnt       = 0;
        items_sent         = 0;
        penalty_reg        = PENALTY_RESET;
        held_valid         = 1'b0;
        held_slot          = '0;
        held_num           = '0;
        held_age           = '0;

        // Hold reset, then release it at a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_penalty();
        test_penalty_extremes();
        test_random_decisions();
        test_back_to_back();

        // Drain outstanding victims before the verdict
        wait_idle();
        if (mismatch_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
rtl/scrv_pkg.sv
rtl/scrv_front.sv
rtl/scrv_queue.sv
rtl/scrv_back.sv
rtl/sampled_cost_recency_victim_select_top.sv
test/tb_sampled_cost_recency_victim_select_top.sv
